/* hdl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the bitmap stream decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // result kinds
    localparam logic [2:0] KIND_INFO    = 3'd0;
    localparam logic [2:0] KIND_PALETTE = 3'd1;
    localparam logic [2:0] KIND_PIXEL   = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_MASK    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_HDR_SIZE = 2'd1;
    localparam logic [1:0] ERR_COMPRESS = 2'd2;
    localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

    // command generators between front and back end
    localparam logic [1:0] GEN_SINGLE = 2'd0;
    localparam logic [1:0] GEN_INFO   = 2'd1;
    localparam logic [1:0] GEN_EXPAND = 2'd2;

    localparam logic [31:0] MASK16_R = 32'h0000_7C00;
    localparam logic [31:0] MASK16_G = 32'h0000_03E0;
    localparam logic [31:0] MASK16_B = 32'h0000_001F;
    localparam logic [31:0] MASK24_R = 32'h00FF_0000;
    localparam logic [31:0] MASK24_G = 32'h0000_FF00;
    localparam logic [31:0] MASK24_B = 32'h0000_00FF;

    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } bsd_in_t;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [11:0] row;
        logic [13:0] column;
        logic [31:0] payload;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [5:0]  bits_per_pixel;
        logic [1:0]  error_code;
        logic        last;
    } bsd_out_t;

    // one command expands to one or more results in the back end
    typedef struct packed {
        logic [1:0]  gen;
        logic [2:0]  last_idx;   // number of results minus one
        logic        flag;       // info: 24-bit masks; expand: 1-bit pixels
        logic [2:0]  item_kind;
        logic [11:0] row;
        logic [13:0] column;
        logic [31:0] payload;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [5:0]  bits_per_pixel;
        logic [1:0]  error_code;
    } bsd_cmd_t;

endpackage

/* hdl/bsd_fifo.sv */
// ----------------------------------------------------------------------------
// bsd_fifo
// Small command queue between the header parser and the result generator.
// ----------------------------------------------------------------------------
module bsd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bsd_pkg::bsd_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bsd_pkg::bsd_cmd_t head_cmd
);
    import bsd_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);

    bsd_cmd_t        mem_reg [FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/bsd_front.sv */
// ----------------------------------------------------------------------------
// bsd_front
// Byte parser: header capture, checks, masks, palette and row tracking.
// Produces one command for every byte that yields results.
// ----------------------------------------------------------------------------
module bsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsd_pkg::bsd_in_t  s_data,
    input  logic              q_full,
    output logic              push,
    output bsd_pkg::bsd_cmd_t push_cmd
);
    import bsd_pkg::*;

    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_HEADER  = 4'd1;
    localparam logic [3:0] PH_INFO    = 4'd2;
    localparam logic [3:0] PH_MASKS   = 4'd3;
    localparam logic [3:0] PH_PALETTE = 4'd4;
    localparam logic [3:0] PH_SKIP    = 4'd5;
    localparam logic [3:0] PH_PIXELS  = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [31:0] o,
                                             input logic [31:0] base, input logic [7:0] d);
        logic [31:0] diff;
        logic [31:0] res;
        diff = o - base;
        res  = old;
        if (o >= base && diff < 32'd4) begin
            res[diff[1:0]*8 +: 8] = d;
        end
        return res;
    endfunction

    logic        accept;
    logic [7:0]  d;

    logic [3:0]  phase_reg, phase_next, phase_cur;
    logic [31:0] off_reg, off_next, off_cur;
    logic [31:0] doff_reg, doff_next, doff_cur;
    logic [7:0]  isize_reg, isize_next, isize_cur;
    logic [12:0] w_reg, w_next, w_cur;
    logic [12:0] h_reg, h_next, h_cur;
    logic [5:0]  dep_reg, dep_next, dep_cur;
    logic [2:0]  mode_reg, mode_next, mode_cur;
    logic [8:0]  colours_reg, colours_next, colours_cur;
    logic [12:0] row_reg, row_next, row_cur;
    logic [14:0] col_reg, col_next, col_cur;
    logic [1:0]  pad_reg, pad_next, pad_cur;
    logic [31:0] acc_reg, acc_next, acc_cur;
    logic [1:0]  shift_reg, shift_next, shift_cur;
    logic [7:0]  hdr0_reg, hdr0_next, hdr0_cur;
    logic [31:0] c_off_reg, c_off_next, c_size_reg, c_size_next;
    logic [31:0] c_w_reg, c_w_next, c_h_reg, c_h_next;
    logic [15:0] c_bits_reg, c_bits_next;
    logic [31:0] c_comp_reg, c_comp_next, c_clr_reg, c_clr_next;

    // finish-info decode
    logic        fi_core, fi_bad_comp, fi_bad_size, fi_def, fi_d16, fi_d24;
    logic [31:0] fi_w32, fi_h32, fi_comp, fi_clr;
    logic [15:0] fi_bits;
    logic [2:0]  fi_mode;
    logic [5:0]  fi_dep;

    // after-masks / enter-skip decode
    logic [5:0]  am_dep;
    logic [31:0] am_clr, am_doff;
    logic [12:0] am_w, am_h;
    logic [8:0]  am_cap, am_colours;
    logic        am_pal, skip_now;
    logic [3:0]  begin_phase;

    // pixel decode
    logic [14:0] rb, base, rem;
    logic [2:0]  bpb;
    logic [1:0]  pad_need;
    logic [3:0]  ppb;
    logic [3:0]  cnt;
    logic [31:0] acc_in;

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;
    assign d       = s_data.data_byte;

    always_comb begin
        if (s_data.start_of_file) begin
            phase_cur = PH_MAGIC;  off_cur = '0;   doff_cur = '0;   isize_cur = '0;
            w_cur = '0;  h_cur = '0;  dep_cur = '0;  mode_cur = '0;  colours_cur = '0;
            row_cur = '0;  col_cur = '0;  pad_cur = '0;  acc_cur = '0;  shift_cur = '0;
            hdr0_cur = '0;
        end else begin
            phase_cur = phase_reg;  off_cur = off_reg;  doff_cur = doff_reg;
            isize_cur = isize_reg;  w_cur = w_reg;  h_cur = h_reg;  dep_cur = dep_reg;
            mode_cur = mode_reg;  colours_cur = colours_reg;  row_cur = row_reg;
            col_cur = col_reg;  pad_cur = pad_reg;  acc_cur = acc_reg;
            shift_cur = shift_reg;  hdr0_cur = hdr0_reg;
        end
    end

    // header field capture, including the byte in flight
    always_comb begin
        logic sof;
        sof         = s_data.start_of_file;
        c_off_next  = put_byte(sof ? '0 : c_off_reg,  off_cur, 32'd10, d);
        c_size_next = put_byte(sof ? '0 : c_size_reg, off_cur, 32'd14, d);
        c_w_next    = put_byte(sof ? '0 : c_w_reg,    off_cur, 32'd18, d);
        c_h_next    = put_byte(sof ? '0 : c_h_reg,    off_cur, 32'd22, d);
        c_bits_next = 16'(put_byte({16'd0, sof ? 16'd0 : c_bits_reg}, off_cur, 32'd28, d));
        c_comp_next = put_byte(sof ? '0 : c_comp_reg, off_cur, 32'd30, d);
        c_clr_next  = put_byte(sof ? '0 : c_clr_reg,  off_cur, 32'd46, d);
    end

    always_comb begin
        fi_core     = (isize_cur == 8'd12);
        fi_w32      = fi_core ? {16'd0, c_w_next[15:0]}  : c_w_next;
        fi_h32      = fi_core ? {16'd0, c_w_next[31:16]} : c_h_next;
        fi_bits     = fi_core ? c_h_next[31:16] : c_bits_next;
        fi_comp     = fi_core ? 32'd0 : c_comp_next;
        fi_clr      = fi_core ? 32'd0 : c_clr_next;
        fi_bad_comp = (fi_comp != 32'd0) && (fi_comp != 32'd3);
        fi_bad_size = (fi_bits == 16'd0) || (fi_bits > 16'd32)
                      || (fi_w32 > 32'(MAX_WIDTH)) || (fi_h32 > 32'(MAX_HEIGHT));
        fi_mode     = (fi_bits == 16'd1 || fi_bits == 16'd4) ? fi_bits[2:0] : 3'd0;
        fi_dep      = (fi_mode != 3'd0) ? 6'd8 : fi_bits[5:0];
        fi_def      = (fi_comp == 32'd0) && (c_off_next == 32'd14 + 32'(isize_cur));
        fi_d16      = (fi_dep == 6'd15) || (fi_dep == 6'd16);
        fi_d24      = (fi_dep == 6'd24) || (fi_dep == 6'd32);

        if (phase_cur == PH_INFO) begin
            am_dep  = fi_dep;
            am_clr  = fi_clr;
            am_doff = c_off_next;
            am_w    = fi_w32[12:0];
            am_h    = fi_h32[12:0];
        end else begin
            am_dep  = dep_cur;
            am_clr  = (isize_cur == 8'd40) ? c_clr_reg : 32'd0;
            am_doff = doff_cur;
            am_w    = w_cur;
            am_h    = h_cur;
        end
        am_pal      = (am_dep <= 6'd8);
        am_cap      = 9'd1 << am_dep[3:0];
        am_colours  = (am_clr == 32'd0 || am_clr > 32'(am_cap)) ? am_cap : am_clr[8:0];
        skip_now    = (off_next >= am_doff);
        begin_phase = (am_w == '0 || am_h == '0) ? PH_DONE : PH_PIXELS;

        bpb  = 3'((7'(dep_cur) + 7'd7) >> 3);
        if (mode_cur == 3'd1) begin
            rb = 15'((14'(w_cur) + 14'd7) >> 3);
        end else if (mode_cur == 3'd4) begin
            rb = 15'((14'(w_cur) + 14'd1) >> 1);
        end else begin
            rb = 15'(w_cur) * 15'(bpb);
        end
        pad_need = ~rb[1:0] + 2'd1;
        ppb      = (mode_cur == 3'd1) ? 4'd8 : 4'd2;
        base     = (mode_cur == 3'd1) ? (col_cur << 3) : (col_cur << 1);
        rem      = 15'(w_cur) - base;
        cnt      = (rem < 15'(ppb)) ? rem[3:0] : ppb;
        acc_in   = acc_cur | (32'(d) << {shift_cur, 3'b000});
    end

    always_comb begin
        phase_next = phase_cur;  doff_next = doff_cur;  isize_next = isize_cur;
        w_next = w_cur;  h_next = h_cur;  dep_next = dep_cur;  mode_next = mode_cur;
        colours_next = colours_cur;  row_next = row_cur;  col_next = col_cur;
        pad_next = pad_cur;  acc_next = acc_cur;  shift_next = shift_cur;
        hdr0_next = (off_cur == 32'd0) ? d : hdr0_cur;
        off_next  = (off_cur == '1) ? off_cur : off_cur + 32'd1;
        push      = 1'b0;
        push_cmd  = '0;

        unique case (phase_cur)
            PH_MAGIC: begin
                if (off_cur == 32'd1) begin
                    if (hdr0_cur == 8'h42 && d == 8'h4D) begin
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = PH_ERROR;
                        push = 1'b1;  push_cmd.item_kind = KIND_ERROR;
                        push_cmd.error_code = ERR_MAGIC;
                    end
                end
            end
            PH_HEADER: begin
                if (off_cur == 32'd17) begin
                    if (c_size_next == 32'd12 || c_size_next == 32'd40) begin
                        isize_next = c_size_next[7:0];
                        phase_next = PH_INFO;
                    end else begin
                        phase_next = PH_ERROR;
                        push = 1'b1;  push_cmd.item_kind = KIND_ERROR;
                        push_cmd.error_code = ERR_HDR_SIZE;
                    end
                end
            end
            PH_INFO: begin
                if (off_cur == 32'd13 + 32'(isize_cur)) begin
                    push = 1'b1;
                    if (fi_bad_comp || fi_bad_size) begin
                        phase_next = PH_ERROR;
                        push_cmd.item_kind  = KIND_ERROR;
                        push_cmd.error_code = fi_bad_comp ? ERR_COMPRESS : ERR_TOO_BIG;
                    end else begin
                        mode_next = fi_mode;  dep_next = fi_dep;
                        w_next = fi_w32[12:0];  h_next = fi_h32[12:0];
                        doff_next = c_off_next;
                        push_cmd.gen       = GEN_INFO;
                        push_cmd.item_kind = KIND_INFO;
                        push_cmd.flag      = fi_d24;
                        push_cmd.last_idx  = (fi_def && (fi_d16 || fi_d24)) ? 3'd3 : 3'd0;
                        if (!fi_def && (fi_d16 || fi_dep == 6'd32)) begin
                            phase_next = PH_MASKS;
                            col_next = '0;  acc_next = '0;  shift_next = '0;
                        end else if (am_pal) begin
                            phase_next = PH_PALETTE;  colours_next = am_colours;
                            col_next = '0;  acc_next = '0;  shift_next = '0;
                        end else if (skip_now) begin
                            phase_next = begin_phase;
                            row_next = '0;  col_next = '0;  pad_next = '0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_MASKS: begin
                if (shift_cur == 2'd3) begin
                    push = 1'b1;
                    push_cmd.item_kind = KIND_MASK;
                    push_cmd.column    = col_cur[13:0];
                    push_cmd.payload   = acc_in;
                    acc_next = '0;  shift_next = '0;  col_next = col_cur + 15'd1;
                    if (col_cur + 15'd1 >= 15'd3) begin
                        if (am_pal) begin
                            phase_next = PH_PALETTE;  colours_next = am_colours;
                            col_next = '0;
                        end else if (skip_now) begin
                            phase_next = begin_phase;
                            row_next = '0;  col_next = '0;  pad_next = '0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end else begin
                    acc_next = acc_in;  shift_next = shift_cur + 2'd1;
                end
            end
            PH_PALETTE: begin
                if (shift_cur == (fi_core ? 2'd2 : 2'd3)) begin
                    push = 1'b1;
                    push_cmd.item_kind = KIND_PALETTE;
                    push_cmd.column    = col_cur[13:0];
                    push_cmd.payload   = acc_in;
                    acc_next = '0;  shift_next = '0;  col_next = col_cur + 15'd1;
                    if (col_cur + 15'd1 >= 15'(colours_cur)) begin
                        if (skip_now) begin
                            phase_next = begin_phase;
                            row_next = '0;  col_next = '0;  pad_next = '0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end else begin
                    acc_next = acc_in;  shift_next = shift_cur + 2'd1;
                end
            end
            PH_SKIP: begin
                if (skip_now) begin
                    phase_next = begin_phase;
                    row_next = '0;  col_next = '0;  pad_next = '0;
                end
            end
            PH_PIXELS: begin
                if (col_cur < rb) begin
                    push = 1'b1;
                    push_cmd.item_kind = KIND_PIXEL;
                    push_cmd.row       = 12'(h_cur - 13'd1 - row_cur);
                    if (mode_cur != 3'd0) begin
                        push_cmd.gen      = GEN_EXPAND;
                        push_cmd.flag     = (mode_cur == 3'd1);
                        push_cmd.column   = base[13:0];
                        push_cmd.last_idx = 3'(cnt - 4'd1);
                        push_cmd.payload  = 32'(d);
                    end else begin
                        push_cmd.column  = col_cur[13:0];
                        push_cmd.payload = 32'(d);
                    end
                    col_next = col_cur + 15'd1;
                end else begin
                    pad_next = pad_cur + 2'd1;
                end
                if (col_next >= rb && pad_next >= pad_need) begin
                    row_next = row_cur + 13'd1;  col_next = '0;  pad_next = '0;
                    if (row_cur + 13'd1 >= h_cur) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase

        push_cmd.image_width    = w_next;
        push_cmd.image_height   = h_next;
        push_cmd.bits_per_pixel = dep_next;
        push = push && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;  off_reg <= '0;  doff_reg <= '0;  isize_reg <= '0;
            w_reg <= '0;  h_reg <= '0;  dep_reg <= '0;  mode_reg <= '0;
            colours_reg <= '0;  row_reg <= '0;  col_reg <= '0;  pad_reg <= '0;
            acc_reg <= '0;  shift_reg <= '0;  hdr0_reg <= '0;
            c_off_reg <= '0;  c_size_reg <= '0;  c_w_reg <= '0;  c_h_reg <= '0;
            c_bits_reg <= '0;  c_comp_reg <= '0;  c_clr_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;  off_reg <= off_next;  doff_reg <= doff_next;
            isize_reg <= isize_next;  w_reg <= w_next;  h_reg <= h_next;
            dep_reg <= dep_next;  mode_reg <= mode_next;  colours_reg <= colours_next;
            row_reg <= row_next;  col_reg <= col_next;  pad_reg <= pad_next;
            acc_reg <= acc_next;  shift_reg <= shift_next;  hdr0_reg <= hdr0_next;
            c_off_reg <= c_off_next;  c_size_reg <= c_size_next;  c_w_reg <= c_w_next;
            c_h_reg <= c_h_next;  c_bits_reg <= c_bits_next;
            c_comp_reg <= c_comp_next;  c_clr_reg <= c_clr_next;
        end
    end

endmodule

/* hdl/bsd_back.sv */
// ----------------------------------------------------------------------------
// bsd_back
// Result generator: turns queued commands into result transactions,
// one per cycle while the result port is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module bsd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  bsd_pkg::bsd_cmd_t head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output bsd_pkg::bsd_out_t m_data
);
    import bsd_pkg::*;

    logic     m_valid_reg, m_valid_next;
    bsd_out_t m_data_reg, res;
    logic [2:0] idx_reg, idx_next;
    logic       load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = (!m_valid_reg || m_ready) && head_valid;
    assign pop     = load && (idx_reg == head_cmd.last_idx);

    always_comb begin
        res.item_kind      = head_cmd.item_kind;
        res.row            = head_cmd.row;
        res.column         = head_cmd.column;
        res.payload        = head_cmd.payload;
        res.image_width    = head_cmd.image_width;
        res.image_height   = head_cmd.image_height;
        res.bits_per_pixel = head_cmd.bits_per_pixel;
        res.error_code     = head_cmd.error_code;
        res.last           = (idx_reg == head_cmd.last_idx);
        unique case (head_cmd.gen)
            GEN_INFO: begin
                if (idx_reg != 3'd0) begin
                    res.item_kind = KIND_MASK;
                    res.column    = 14'(idx_reg - 3'd1);
                    unique case (idx_reg)
                        3'd1:    res.payload = head_cmd.flag ? MASK24_R : MASK16_R;
                        3'd2:    res.payload = head_cmd.flag ? MASK24_G : MASK16_G;
                        default: res.payload = head_cmd.flag ? MASK24_B : MASK16_B;
                    endcase
                end
            end
            GEN_EXPAND: begin
                res.column = head_cmd.column + 14'(idx_reg);
                if (head_cmd.flag) begin
                    res.payload = 32'(head_cmd.payload[3'd7 - idx_reg]);
                end else begin
                    res.payload = 32'(idx_reg[0] ? head_cmd.payload[3:0]
                                                 : head_cmd.payload[7:4]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = pop ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

/* hdl/bmp_stream_decoder.sv */
// path: each result is registered in the command queue and then in the output stage
// throughput: one byte per cycle while results keep up; the result port gives one
// transaction per cycle while m_ready is high, so a byte that yields n results holds
// it for n transactions; a four-entry command queue absorbs 1- and 4-bit expansion bursts
// reset: synchronous active-low aresetn clears parser state and empties the queue
// ----------------------------------------------------------------------------
// bmp_stream_decoder
// Uncompressed bitmap file decoder: parser front end, command queue and
// result generator back end.
// ----------------------------------------------------------------------------
module bmp_stream_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsd_pkg::bsd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bsd_pkg::bsd_out_t m_data
);
    import bsd_pkg::*;

    logic     q_full, push, pop, head_valid;
    bsd_cmd_t push_cmd, head_cmd;

    bsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bsd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* tb/tb_bmp_stream_decoder.sv */
// ----------------------------------------------------------------------------
// tb_bmp_stream_decoder
// Feeds bitmap byte streams (directed files, random well-formed files and
// noise) with random idling on both channels, and checks every result against
// an in-bench model of the header parser, palette reader and pixel expander.
// ----------------------------------------------------------------------------
module tb_bmp_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import bsd_pkg::*;

    localparam logic [3:0] PH_MAGIC = 4'd0, PH_HEADER = 4'd1, PH_INFO = 4'd2,
        PH_MASKS = 4'd3, PH_PALETTE = 4'd4, PH_SKIP = 4'd5, PH_PIXELS = 4'd6,
        PH_DONE = 4'd7, PH_ERROR = 4'd8;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bsd_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bsd_out_t m_data;

    bmp_stream_decoder DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder model state
    logic [3:0]  phase;
    logic [31:0] pos, pix_start, accum;
    logic [5:0]  shift;
    logic [7:0]  hdr_len;
    logic [12:0] img_w, img_h;
    logic [5:0]  depth;
    logic [2:0]  expand;
    logic [8:0]  n_colours;
    logic [12:0] row_idx;
    logic [14:0] col_idx;
    logic [1:0]  pad_idx;
    logic [7:0]  hdr_buf [54];

    bsd_out_t expected_results[$];
    int errors = 0;
    bit hold_results = 0;

    // byte stream to send
    bsd_in_t byte_stream[$];
    bit      stream_checked[$];
    bsd_out_t stream_expect[$];

    task automatic report(input string what, input bsd_out_t got, input bsd_out_t want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic [31:0] le16(input int o);
        return {16'h0, hdr_buf[o + 1], hdr_buf[o]};
    endfunction

    function automatic logic [31:0] le32(input int o);
        return {hdr_buf[o + 3], hdr_buf[o + 2], hdr_buf[o + 1], hdr_buf[o]};
    endfunction

    function automatic void model_clear();
        phase = PH_MAGIC; pos = 0; shift = 0; pix_start = 0; hdr_len = 0;
        img_w = 0; img_h = 0; depth = 0; expand = 0; n_colours = 0;
        row_idx = 0; col_idx = 0; pad_idx = 0; accum = 0;
        foreach (hdr_buf[i]) hdr_buf[i] = 8'h00;
    endfunction

    function automatic void push_result(ref bsd_out_t res[$], input logic [2:0] kind,
            input logic [11:0] r, input logic [13:0] c, input logic [31:0] pl,
            input logic [1:0] err);
        bsd_out_t t;
        t.item_kind = kind; t.row = r; t.column = c; t.payload = pl;
        t.image_width = img_w; t.image_height = img_h; t.bits_per_pixel = depth;
        t.error_code = err; t.last = 1'b0;
        if (res.size() < 8) res.push_back(t);
    endfunction

    function automatic void start_rows();
        row_idx = 0; col_idx = 0; pad_idx = 0;
        phase = (img_w == 0 || img_h == 0) ? PH_DONE : PH_PIXELS;
    endfunction

    function automatic void go_skip();
        phase = PH_SKIP;
        if (pos >= pix_start) start_rows();
    endfunction

    function automatic void palette_or_skip(input logic [31:0] clr);
        logic [31:0] cap;
        if (depth <= 8) begin
            cap = 32'd1 << depth;
            n_colours = 9'((clr == 0 || clr > cap) ? cap : clr);
            phase = PH_PALETTE; col_idx = 0; accum = 0; shift = 0;
        end else begin
            go_skip();
        end
    endfunction

    function automatic void close_info(ref bsd_out_t res[$]);
        logic [31:0] w, h, bits, comp, clr;
        if (hdr_len == 12) begin
            w = le16(18); h = le16(20); bits = le16(24); comp = 0; clr = 0;
        end else begin
            w = le32(18); h = le32(22); bits = le16(28); comp = le32(30); clr = le32(46);
        end
        if (comp != 0 && comp != 3) begin
            phase = PH_ERROR; push_result(res, KIND_ERROR, 0, 0, 0, ERR_COMPRESS);
            return;
        end
        if (bits == 0 || bits > 32 || w > MAX_WIDTH || h > MAX_HEIGHT) begin
            phase = PH_ERROR; push_result(res, KIND_ERROR, 0, 0, 0, ERR_TOO_BIG);
            return;
        end
        expand = (bits == 1 || bits == 4) ? bits[2:0] : 3'd0;
        depth = (expand != 0) ? 6'd8 : bits[5:0];
        img_w = w[12:0]; img_h = h[12:0];
        pix_start = le32(10);
        push_result(res, KIND_INFO, 0, 0, 0, 2'd0);
        if (comp == 0 && pix_start == 14 + hdr_len) begin
            if (depth == 15 || depth == 16) begin
                push_result(res, KIND_MASK, 0, 0, MASK16_R, 2'd0);
                push_result(res, KIND_MASK, 0, 1, MASK16_G, 2'd0);
                push_result(res, KIND_MASK, 0, 2, MASK16_B, 2'd0);
            end else if (depth == 24 || depth == 32) begin
                push_result(res, KIND_MASK, 0, 0, MASK24_R, 2'd0);
                push_result(res, KIND_MASK, 0, 1, MASK24_G, 2'd0);
                push_result(res, KIND_MASK, 0, 2, MASK24_B, 2'd0);
            end
        end else if (depth == 15 || depth == 16 || depth == 32) begin
            phase = PH_MASKS; col_idx = 0; accum = 0; shift = 0;
            return;
        end
        palette_or_skip(clr);
    endfunction

    function automatic void pixel_step(ref bsd_out_t res[$], input logic [7:0] d);
        logic [31:0] rb, pad, r, px, ppb;
        if (expand == 1) rb = (img_w + 7) >> 3;
        else if (expand == 4) rb = (img_w + 1) >> 1;
        else rb = img_w * ((depth + 7) >> 3);
        pad = (4 - (rb & 3)) & 3;
        r = img_h - 1 - row_idx;
        if (col_idx < rb) begin
            if (expand != 0) begin
                ppb = 8 / expand;
                for (int k = 0; k < ppb; k++) begin
                    px = col_idx * ppb + k;
                    if (px >= img_w) break;
                    push_result(res, KIND_PIXEL, r[11:0], px[13:0],
                        (d >> (8 - expand - k * expand)) & ((1 << expand) - 1), 2'd0);
                end
            end else begin
                push_result(res, KIND_PIXEL, r[11:0], col_idx[13:0], 32'(d), 2'd0);
            end
            col_idx++;
        end else begin
            pad_idx++;
        end
        if (col_idx >= rb && pad_idx >= pad) begin
            row_idx++; col_idx = 0; pad_idx = 0;
            if (row_idx >= img_h) phase = PH_DONE;
        end
    endfunction

    function automatic void decode_byte(input bsd_in_t b, ref bsd_out_t res[$]);
        logic [31:0] o, sz;
        logic [7:0] d;
        d = b.data_byte;
        res.delete();
        if (b.start_of_file) model_clear();
        o = pos;
        if (pos != 32'hFFFF_FFFF) pos++;
        if (o < 54) hdr_buf[o] = d;
        case (phase)
            PH_MAGIC: begin
                if (o == 1) begin
                    if (hdr_buf[0] == 8'h42 && d == 8'h4D) phase = PH_HEADER;
                    else begin
                        phase = PH_ERROR; push_result(res, KIND_ERROR, 0, 0, 0, ERR_MAGIC);
                    end
                end
            end
            PH_HEADER: begin
                if (o == 17) begin
                    sz = le32(14);
                    if (sz == 12 || sz == 40) begin
                        hdr_len = sz[7:0]; phase = PH_INFO;
                    end else begin
                        phase = PH_ERROR;
                        push_result(res, KIND_ERROR, 0, 0, 0, ERR_HDR_SIZE);
                    end
                end
            end
            PH_INFO: if (o == 13 + hdr_len) close_info(res);
            PH_MASKS: begin
                accum |= {24'h0, d} << shift;
                shift += 8;
                if (shift >= 32) begin
                    push_result(res, KIND_MASK, 0, col_idx[13:0], accum, 2'd0);
                    accum = 0; shift = 0; col_idx++;
                    if (col_idx >= 3) palette_or_skip(hdr_len == 40 ? le32(46) : 32'd0);
                end
            end
            PH_PALETTE: begin
                accum |= {24'h0, d} << shift;
                shift += 8;
                if (shift >= ((hdr_len == 12) ? 24 : 32)) begin
                    push_result(res, KIND_PALETTE, 0, col_idx[13:0], accum, 2'd0);
                    accum = 0; shift = 0; col_idx++;
                    if (col_idx >= n_colours) go_skip();
                end
            end
            PH_SKIP: if (pos >= pix_start) start_rows();
            PH_PIXELS: pixel_step(res, d);
            default: ;
        endcase
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stream building
    function automatic void put(input logic [7:0] d, input bit sof = 0);
        bsd_in_t b;
        b.data_byte = d; b.start_of_file = sof;
        byte_stream.push_back(b);
        stream_checked.push_back(0);
    endfunction

    // bytes past the fourth are zero
    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) put((i < 4) ? v[8 * i +: 8] : 8'h00);
    endfunction

    // one file: core or info header, optional masks, palette, gap, pixel rows
    function automatic void build_file(input bit core, input int bits, input int w,
            input int h, input logic [31:0] comp, input logic [31:0] clr,
            input int gap, input bit file_masks);
        int hs, off, pal, ent, rb, npix;
        hs = core ? 12 : 40;
        ent = core ? 3 : 4;
        pal = 0;
        if (bits <= 8 && bits > 0) begin
            pal = 1 << bits;
            if (!core && clr != 0 && clr < pal) pal = clr;
        end
        off = 14 + hs + (file_masks ? 12 : 0) + pal * ent + gap;
        put(8'h42, 1); put(8'h4D);
        put_le(off + 64, 4); put_le(0, 4); put_le(off, 4);
        put_le(hs, 4);
        if (core) begin
            put_le(w, 2); put_le(h, 2); put_le(1, 2); put_le(bits, 2);
        end else begin
            put_le(w, 4); put_le(h, 4); put_le(1, 2); put_le(bits, 2);
            put_le(comp, 4); put_le(0, 4); put_le($urandom, 4); put_le($urandom, 4);
            put_le(clr, 4); put_le(0, 4);
        end
        if (file_masks) for (int i = 0; i < 3; i++) put_le($urandom, 4);
        for (int i = 0; i < pal * ent + gap; i++) put($urandom_range(0, 255));
        if (bits == 1) rb = (w + 7) / 8;
        else if (bits == 4) rb = (w + 1) / 2;
        else rb = w * ((bits + 7) / 8);
        npix = ((rb + 3) / 4) * 4 * h;
        for (int i = 0; i < npix; i++) put($urandom_range(0, 255));
    endfunction

    function automatic void random_file();
        int depths[8] = '{1, 4, 8, 15, 16, 24, 32, 2};
        int bits;
        bit core, masks;
        logic [31:0] comp;
        bits = depths[$urandom_range(0, 7)];
        core = ($urandom_range(0, 3) == 0);
        // keep 8-bit palettes short
        if (bits == 8) core = 0;
        comp = (!core && $urandom_range(0, 2) == 0) ? 32'd3 : 32'd0;
        masks = !core && (bits == 15 || bits == 16 || bits == 32) &&
                (comp == 3 || $urandom_range(0, 1));
        build_file(core, bits, $urandom_range(0, 7), $urandom_range(0, 3), comp,
            (core || bits > 8) ? 0 :
            ((bits == 8) ? $urandom_range(1, 3) : $urandom_range(0, 3)),
            $urandom_range(0, 2), masks);
    endfunction

    // directed error file: bad header fields right after a valid prefix
    function automatic void error_file(input int kind);
        put(8'h42, 1); put(kind == 0 ? 8'h4E : 8'h4D);
        if (kind == 0) return;
        put_le(200, 4); put_le(0, 4); put_le(54, 4);
        put_le(kind == 1 ? 41 : 40, 4);
        if (kind == 1) return;
        put_le(kind == 4 ? 4097 : 8, 4);
        put_le(kind == 5 ? 32'hFFFF_FFFF : 2, 4);
        put_le(1, 2); put_le(kind == 6 ? 33 : 8, 2);
        put_le(kind == 2 ? 1 : 0, 4);
        put_le(0, 20);
    endfunction

    // ------------------------------------------------------------------
    initial begin : sender
        bsd_out_t res[$];
        bsd_out_t t;
        int wait_n;
        model_clear();
        // directed table; typed expectations only for errors
        error_file(0);
        t = '0; t.item_kind = KIND_ERROR; t.error_code = ERR_MAGIC; t.last = 1;
        stream_checked[byte_stream.size() - 1] = 1; stream_expect.push_back(t);
        error_file(1);
        t.error_code = ERR_HDR_SIZE;
        stream_checked[byte_stream.size() - 1] = 1; stream_expect.push_back(t);
        for (int i = 0; i < 8; i++) put(8'hFF);    // ignored after error
        error_file(2); error_file(4); error_file(5); error_file(6);
        build_file(1, 1, 9, 2, 0, 0, 0, 0);
        // data offset already passed
        put(8'h42, 1); put(8'h4D); put_le(0, 4); put_le(0, 4); put_le(5, 4);
        put_le(40, 4); put_le(1, 4); put_le(1, 4); put_le(1, 2); put_le(24, 2);
        put_le(0, 24); put_le(32'hA5C3_7E81, 4);
        while (byte_stream.size() < 420) begin
            if ($urandom_range(0, 9) == 0) put($urandom_range(0, 255), $urandom_range(0, 1));
            else random_file();
        end
        wait (aresetn);
        for (int i = 0; i < byte_stream.size(); i++) begin
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
            if (wait_n > 0) begin
                s_valid <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            if (i == 150) begin
                hold_results = 1;
            end
            if (i == 380) begin
                s_valid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= byte_stream[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            decode_byte(byte_stream[i], res);
            if (stream_checked[i]) begin
                t = stream_expect.pop_front();
                if (res.size() != 1 || res[0] !== t) report("table", res[0], t);
            end
            foreach (res[k]) expected_results.push_back(res[k]);
        end
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("** bmp_stream_decoder: PASSED **");
        else $display("** bmp_stream_decoder: FAILED **");
        $finish;
    end

    initial begin : receiver
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_results = 0;
            end
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        bsd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected", m_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.item_kind !== want.item_kind) report("item_kind", m_data, want);
                else if (m_data.row !== want.row) report("row", m_data, want);
                else if (m_data.column !== want.column) report("column", m_data, want);
                else if (m_data.payload !== want.payload) report("payload", m_data, want);
                else if (m_data.image_width !== want.image_width ||
                         m_data.image_height !== want.image_height ||
                         m_data.bits_per_pixel !== want.bits_per_pixel)
                    report("geometry", m_data, want);
                else if (m_data.error_code !== want.error_code) report("error_code", m_data, want);
                else if (m_data.last !== want.last) report("last", m_data, want);
            end
        end
    end

    initial begin : watchdog
        #20ms;
        $display("** bmp_stream_decoder: FAILED **");
        $finish;
    end
endmodule
